[rtl/e2q_pkg.sv]
// Shared types, constants and the arctangent table for the Euler-to-quaternion block.
package e2q_pkg;

  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 14;
  localparam int CW            = 34;  // CORDIC datapath width, 30 fraction bits
  localparam int SCW           = 18;  // rounded sine / cosine, Q2.15
  localparam int PW            = 2 * SCW;
  localparam int TW            = PW + SCW;
  localparam int SHW           = $clog2(CORDIC_STAGES);
  localparam int QW            = 16;

  typedef logic signed [CW-1:0]  cval_t;
  typedef logic signed [SCW-1:0] sc_t;
  typedef logic [SHW-1:0]        shift_t;

  localparam cval_t PI_FIX      = 34'sd3373259426;
  localparam cval_t HALF_PI_FIX = 34'sd1686629713;
  localparam cval_t CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;

  localparam cval_t ATAN_TAB [30] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  neg_cos;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;  // 0: a, 1: b, 2: g
    logic        last;
  } cword_t;

endpackage

[rtl/e2q_angle_if.sv]
// Input channel: three angles and the last-frame flag.
interface e2q_angle_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        first_angle;
  logic signed [15:0]        second_angle;
  logic signed [15:0]        third_angle;
  logic                      last_frame;

  modport source (output valid, first_angle, second_angle, third_angle, last_frame,
                  input ready);
  modport sink (input valid, first_angle, second_angle, third_angle, last_frame,
                output ready);
endinterface

[rtl/e2q_quat_if.sv]
// Output channel: quaternion vector part and the last-frame flag.
interface e2q_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               last_frame_out;

  modport source (output valid, quat_x, quat_y, quat_z, last_frame_out, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, last_frame_out, output ready);
endinterface

[rtl/e2q_cell.sv]
// One CORDIC rotation step for all three angles, with its own pipeline register.
module e2q_cell (
  input  logic            clk,
  input  logic            rst,
  input  e2q_pkg::shift_t shift,
  input  e2q_pkg::cval_t  atan,
  input  logic            in_valid,
  output logic            in_ready,
  input  e2q_pkg::cword_t in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output e2q_pkg::cword_t out_word
);
  import e2q_pkg::*;

  cword_t word_next;

  always_comb begin
    word_next = in_word;
    for (int k = 0; k < 3; k++) begin
      if (!in_word.lane[k].z[CW-1]) begin
        word_next.lane[k].x = in_word.lane[k].x - (in_word.lane[k].y >>> shift);
        word_next.lane[k].y = in_word.lane[k].y + (in_word.lane[k].x >>> shift);
        word_next.lane[k].z = in_word.lane[k].z - atan;
      end else begin
        word_next.lane[k].x = in_word.lane[k].x + (in_word.lane[k].y >>> shift);
        word_next.lane[k].y = in_word.lane[k].y - (in_word.lane[k].x >>> shift);
        word_next.lane[k].z = in_word.lane[k].z + atan;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

[rtl/e2q_combine.sv]
// Rounds sines and cosines and forms the three quaternion components in three stages.
module e2q_combine (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  e2q_pkg::cword_t in_word,
  e2q_quat_if.source      quats
);
  import e2q_pkg::*;

  typedef logic signed [PW-1:0]  pprod_t;
  typedef logic signed [TW-1:0]  tprod_t;
  typedef logic signed [TW+1:0]  acc_t;
  typedef logic signed [TW-30:0] qf_t;

  sc_t s [3];
  sc_t c [3];
  cval_t xc [3];

  logic   v1, v2, r1, r2, r3;
  pprod_t cbca, sbsa, sbca, cbsa;
  sc_t    sg1, cg1;
  logic   last1, last2;
  tprod_t t1, t2, t3, t4, t5, t6;

  function automatic logic signed [QW-1:0] to_q14(input acc_t acc);
    qf_t q;
    begin
      q = qf_t'((acc + acc_t'(64'sd1 << 30)) >>> 31);
      if (q > qf_t'(Q_ONE)) begin
        to_q14 = Q_ONE;
      end else if (q < -qf_t'(Q_ONE)) begin
        to_q14 = -Q_ONE;
      end else begin
        to_q14 = q[QW-1:0];
      end
    end
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xc[k] = in_word.lane[k].neg_cos ? -in_word.lane[k].x : in_word.lane[k].x;
      s[k]  = sc_t'((in_word.lane[k].y + cval_t'(1 << 14)) >>> 15);
      c[k]  = sc_t'((xc[k] + cval_t'(1 << 14)) >>> 15);
    end
  end

  assign r3       = !quats.valid || quats.ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      quats.valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) quats.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      cbca  <= PW'(c[1]) * PW'(c[0]);
      sbsa  <= PW'(s[1]) * PW'(s[0]);
      sbca  <= PW'(s[1]) * PW'(c[0]);
      cbsa  <= PW'(c[1]) * PW'(s[0]);
      sg1   <= s[2];
      cg1   <= c[2];
      last1 <= in_word.last;
    end
    if (r2 && v1) begin
      t1    <= TW'(sg1) * TW'(cbca);
      t2    <= TW'(cg1) * TW'(sbsa);
      t3    <= TW'(cg1) * TW'(sbca);
      t4    <= TW'(sg1) * TW'(cbsa);
      t5    <= TW'(cg1) * TW'(cbsa);
      t6    <= TW'(sg1) * TW'(sbca);
      last2 <= last1;
    end
    if (r3 && v2) begin
      quats.quat_x         <= to_q14(acc_t'(t1) - acc_t'(t2));
      quats.quat_y         <= to_q14(acc_t'(t3) + acc_t'(t4));
      quats.quat_z         <= to_q14(acc_t'(t5) - acc_t'(t6));
      quats.last_frame_out <= last2;
    end
  end

endmodule

[rtl/euler_to_quaternion_vector.sv]
// Top level: Euler angles to quaternion vector part through a chain of CORDIC cells.
// Usage:
//   angles is the input channel: three signed Q2.13 angles and a last-frame flag.
//   quats is the output channel: q1, q2, q3 in signed Q1.14, saturated to +-1,
//   and the last-frame flag copied through.
//   A word is taken when valid and ready are both high on either channel.
// Path: an accepted input word passes the register of each CORDIC cell,
//   then the pair products, the triple products and the final sums.
// Throughput: one word per cycle while the receiver takes words; the cell
//   chain and the product stages each hold one word and pass it on.
// Stall: each stage holds its word while the next is full, so a stalled
//   receiver fills the pipeline; angles.ready drops only when every stage
//   holds a word and the output word is not taken.
// Reset: rst clears all valid flags; no word is in flight afterwards.
module euler_to_quaternion_vector (
  input  logic        clk,
  input  logic        rst,
  e2q_angle_if.sink   angles,
  e2q_quat_if.source  quats
);
  import e2q_pkg::*;

  cword_t word [CORDIC_STAGES+1];
  logic   vld  [CORDIC_STAGES+1];
  logic   rdy  [CORDIC_STAGES+1];
  logic signed [ANGLE_WIDTH-1:0] ang [3];

  assign ang[0] = angles.first_angle;
  assign ang[1] = angles.second_angle;
  assign ang[2] = angles.third_angle;

  // Half angle at 30 fraction bits, folded into [-pi/2, pi/2].
  always_comb begin
    cval_t r;
    word[0].last = angles.last_frame;
    for (int k = 0; k < 3; k++) begin
      r = cval_t'(ang[k]) <<< 16;
      word[0].lane[k].x       = CORDIC_GAIN;
      word[0].lane[k].y       = '0;
      word[0].lane[k].neg_cos = 1'b0;
      word[0].lane[k].z       = r;
      if (r > HALF_PI_FIX) begin
        word[0].lane[k].z       = PI_FIX - r;
        word[0].lane[k].neg_cos = 1'b1;
      end else if (r < -HALF_PI_FIX) begin
        word[0].lane[k].z       = -PI_FIX - r;
        word[0].lane[k].neg_cos = 1'b1;
      end
    end
  end

  assign vld[0]       = angles.valid;
  assign angles.ready = rdy[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    e2q_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift_t'(i)),
      .atan     (ATAN_TAB[i]),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .in_word  (word[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .out_word (word[i+1])
    );
  end

  e2q_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .in_valid(vld[CORDIC_STAGES]),
    .in_ready(rdy[CORDIC_STAGES]),
    .in_word (word[CORDIC_STAGES]),
    .quats   (quats)
  );

  a_range: assert property (@(posedge clk) disable iff (rst)
    quats.valid |-> (quats.quat_x <= Q_ONE && quats.quat_x >= -Q_ONE &&
                     quats.quat_y <= Q_ONE && quats.quat_y >= -Q_ONE &&
                     quats.quat_z <= Q_ONE && quats.quat_z >= -Q_ONE))
    else $error("quaternion component out of range");

  a_reset_empty: assert property (@(posedge clk) rst |=> !quats.valid)
    else $error("output valid right after reset");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !angles.ready |-> (quats.valid && !quats.ready))
    else $error("input stalled while output not stalled");

endmodule

[sim/tb.sv]
// Testbench for euler_to_quaternion_vector: random and corner angles checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import e2q_pkg::*;

  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam int     N_RANDOM   = 630;

  typedef struct {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               last;
  } quat_word_t;

  logic clk;
  logic rst;
  int   n_errors;
  bit   no_idle;

  e2q_angle_if angles ();
  e2q_quat_if  quats ();

  euler_to_quaternion_vector dut (
    .clk    (clk),
    .rst    (rst),
    .angles (angles),
    .quats  (quats)
  );

  // sine and cosine of half the angle, Q2.15
  function automatic void half_angle_trig(input logic signed [15:0] ang,
                                          output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = longint'(ang) * 65536;
    flip = 0;
    r = r % TWO_PI_Q30;
    if (r > longint'(PI_FIX)) r = r - TWO_PI_Q30;
    if (r < -longint'(PI_FIX)) r = r + TWO_PI_Q30;
    if (r > longint'(HALF_PI_FIX)) begin
      r = longint'(PI_FIX) - r;
      flip = 1;
    end else if (r < -longint'(HALF_PI_FIX)) begin
      r = -longint'(PI_FIX) - r;
      flip = 1;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    if (flip) x = -x;
    s = (y + (64'sd1 <<< 14)) >>> 15;
    c = (x + (64'sd1 <<< 14)) >>> 15;
  endfunction

  function automatic logic signed [15:0] sat_q14(input longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 30)) >>> 31;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  class quat_scoreboard;
    quat_word_t pending[$];

    function void note_angles(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] g, logic last);
      longint sa, ca, sb, cb, sg, cg;
      quat_word_t w;
      half_angle_trig(a, sa, ca);
      half_angle_trig(b, sb, cb);
      half_angle_trig(g, sg, cg);
      w.qx = sat_q14(sg * cb * ca - cg * sb * sa);
      w.qy = sat_q14(cg * sb * ca + sg * cb * sa);
      w.qz = sat_q14(cg * cb * sa - sg * sb * ca);
      w.last = last;
      pending.push_back(w);
    endfunction

    // returns an empty string when the word matches
    function string check_quat(quat_word_t got);
      quat_word_t w;
      if (pending.size() == 0) return "result word with nothing expected";
      w = pending.pop_front();
      if (got.qx !== w.qx) return $sformatf("quat_x %0d, expected %0d", got.qx, w.qx);
      if (got.qy !== w.qy) return $sformatf("quat_y %0d, expected %0d", got.qy, w.qy);
      if (got.qz !== w.qz) return $sformatf("quat_z %0d, expected %0d", got.qz, w.qz);
      if (got.last !== w.last)
        return $sformatf("last_frame_out %0b, expected %0b", got.last, w.last);
      return "";
    endfunction
  endclass

  quat_scoreboard sb;

  task automatic report(string msg);
    n_errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("euler_to_quaternion_vector regression: fail");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  // output side: check, then decide the ready for the next cycle
  int hold;
  always @(posedge clk) begin
    quat_word_t got;
    string msg;
    if (rst) begin
      hold = 0;
      quats.ready <= 1'b0;
    end else begin
      if (quats.valid && quats.ready) begin
        got.qx = quats.quat_x;
        got.qy = quats.quat_y;
        got.qz = quats.quat_z;
        got.last = quats.last_frame_out;
        msg = sb.check_quat(got);
        if (msg != "") report(msg);
        hold = draw_gap();
      end
      if (hold > 0) begin
        hold--;
        quats.ready <= 1'b0;
      end else begin
        quats.ready <= 1'b1;
      end
    end
  end

  task automatic send_angles(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] g, logic last);
    int gap;
    angles.valid        <= 1'b1;
    angles.first_angle  <= a;
    angles.second_angle <= b;
    angles.third_angle  <= g;
    angles.last_frame   <= last;
    do @(posedge clk); while (!angles.ready);
    sb.note_angles(a, b, g, last);
    gap = draw_gap();
    if (gap > 0) begin
      angles.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_angle();
    // mostly inside +-pi, sometimes any pattern
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  initial begin
    logic signed [15:0] corner [12];
    corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768, 16'sd12868,
               -16'sd12868, 16'sd1, -16'sd1, 16'sd25735, 16'sd6434, 16'sd19302};
    sb = new();
    n_errors = 0;
    no_idle = 0;
    rst = 1'b1;
    angles.valid <= 1'b0;
    angles.first_angle <= '0;
    angles.second_angle <= '0;
    angles.third_angle <= '0;
    angles.last_frame <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners on all three angles at once, rotated through the list, then chosen combinations
    for (int i = 0; i < 12; i++)
      send_angles(corner[i], corner[(i + 5) % 12], corner[(i + 9) % 12], i[0]);
    send_angles(16'sd25736, 16'sd25736, 16'sd25736, 1'b1);
    send_angles(-16'sd25736, -16'sd25736, -16'sd25736, 1'b0);
    send_angles(16'sd32767, -16'sd32768, 16'sd32767, 1'b1);
    send_angles(16'sd12868, 16'sd12868, 16'sd12868, 1'b0);
    send_angles(16'sd0, 16'sd12868, 16'sd0, 1'b1);
    send_angles(-16'sd1, 16'sd1, -16'sd32768, 1'b0);

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = ((n / 90) % 3) == 2;
      send_angles(rand_angle(), rand_angle(), rand_angle(), $urandom_range(0, 7) == 0);
    end
    angles.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0)
      $display("euler_to_quaternion_vector regression: pass");
    else
      $display("euler_to_quaternion_vector regression: fail");
    $finish;
  end

endmodule
